FILE: hdl/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/cds420_pkg.sv
package cds420_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int DIM_W       = 13;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GEO_W       = (DIM_W > $clog2(MAX_WIDTH) + 1) ? DIM_W
                                                                 : $clog2(MAX_WIDTH) + 1;
    localparam int MAX_W_EVEN  = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int MAX_H_EVEN  = MAX_HEIGHT - (MAX_HEIGHT % 2);

    localparam int SAMPLE_W    = 8;
    localparam int SUM_W       = SAMPLE_W + 1;
    localparam logic [SAMPLE_W-1:0] NEUTRAL = 8'h80;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] FORMAT_RESET = 2'd1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

    typedef enum logic [1:0] {
        FMT_LUMA = 2'd0,
        FMT_420  = 2'd1,
        FMT_422  = 2'd2,
        FMT_444  = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    // per-request controls handed from the sequencer to both lanes
    typedef struct packed {
        fmt_t              fmt;
        logic              held_we;
        logic              mem_we;
        logic              mem_re;
        logic [ADDR_W-1:0] addr;
    } lane_ctl_t;

endpackage

FILE: hdl/cds420_ctrl.sv
module cds420_ctrl
    import cds420_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    input  logic                  accept,
    output lane_ctl_t             lane_ctl,
    output logic                  emit,
    output logic                  last
);

    fmt_t             fmt_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             cfg_wr;
    logic [1:0]       reg_idx;
    logic [GEO_W-1:0] w_even, h_even, w_clamp, h_clamp;
    logic [GEO_W-1:0] cols, rows;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic             last_col, last_row, odd_col, odd_row;

    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        case (reg_idx)
            REG_FORMAT: prdata = {{(APB_DATA_W-2){1'b0}}, fmt_reg};
            REG_WIDTH:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, height_reg};
            default:    prdata = '0;
        endcase
    end

    // frame geometry: drop the low bit, clamp into 2 .. max
    always_comb begin
        w_even = GEO_W'({width_reg[DIM_W-1:1], 1'b0});
        h_even = GEO_W'({height_reg[DIM_W-1:1], 1'b0});
        if (w_even < GEO_W'(2))
            w_clamp = GEO_W'(2);
        else if (w_even > GEO_W'(MAX_W_EVEN))
            w_clamp = GEO_W'(MAX_W_EVEN);
        else
            w_clamp = w_even;
        if (h_even < GEO_W'(2))
            h_clamp = GEO_W'(2);
        else if (h_even > GEO_W'(MAX_H_EVEN))
            h_clamp = GEO_W'(MAX_H_EVEN);
        else
            h_clamp = h_even;
        cols = (fmt_reg == FMT_444) ? w_clamp : (w_clamp >> 1);
        rows = (fmt_reg == FMT_422 || fmt_reg == FMT_444) ? h_clamp : (h_clamp >> 1);
    end

    always_comb begin
        col_eff  = (GEO_W'(col_reg) >= cols) ? '0 : col_reg;
        row_eff  = (GEO_W'(row_reg) >= rows) ? '0 : row_reg;
        last_col = (GEO_W'(col_eff) == cols - GEO_W'(1));
        last_row = (GEO_W'(row_eff) == rows - GEO_W'(1));
        odd_col  = col_eff[0];
        odd_row  = row_eff[0];
        last     = last_col && last_row;

        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_eff + ROW_W'(1);
        end else begin
            col_next = col_eff + COL_W'(1);
            row_next = row_eff;
        end

        lane_ctl.fmt     = fmt_reg;
        lane_ctl.held_we = 1'b0;
        lane_ctl.mem_we  = 1'b0;
        lane_ctl.mem_re  = 1'b0;
        lane_ctl.addr    = col_eff[ADDR_W-1:0];
        emit             = 1'b0;
        case (fmt_reg)
            FMT_LUMA, FMT_420: begin
                emit = 1'b1;
            end
            FMT_422: begin
                lane_ctl.mem_we = !odd_row;
                lane_ctl.mem_re = odd_row;
                emit            = odd_row;
            end
            FMT_444: begin
                // horizontal pair sums share one store entry
                lane_ctl.addr    = col_eff[COL_W-1:1];
                lane_ctl.held_we = !odd_col;
                lane_ctl.mem_we  = odd_col && !odd_row;
                lane_ctl.mem_re  = odd_col && odd_row;
                emit             = odd_col && odd_row;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= fmt_t'(FORMAT_RESET);
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FORMAT: begin
                    fmt_reg <= fmt_t'(pwdata[1:0]);
                    col_reg <= '0;
                    row_reg <= '0;
                end
                REG_WIDTH: begin
                    width_reg <= pwdata[DIM_W-1:0];
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                REG_HEIGHT: begin
                    height_reg <= pwdata[DIM_W-1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default: begin
                    col_reg <= col_reg;
                end
            endcase
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hdl/cds420_lane.sv
module cds420_lane
    import cds420_pkg::*;
(
    input  logic                aclk,
    input  logic                accept,
    input  lane_ctl_t           lane_ctl,
    input  logic [SAMPLE_W-1:0] sample,
    output logic [SAMPLE_W-1:0] result
);

    logic [SUM_W-1:0]    store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] held_reg;
    logic [SUM_W-1:0]    rd_reg;
    logic [SUM_W-1:0]    sum_reg;
    fmt_t                fmt_reg;
    logic [SUM_W-1:0]    sum_in;
    logic [SUM_W+1:0]    total;

    // 4:2:2 keeps the bare sample, 4:4:4 the horizontal pair sum
    assign sum_in = (lane_ctl.fmt == FMT_444) ? ({1'b0, held_reg} + {1'b0, sample})
                                              : {1'b0, sample};

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (lane_ctl.held_we)
                held_reg <= sample;
            if (lane_ctl.mem_we)
                store_mem[lane_ctl.addr] <= sum_in;
            if (lane_ctl.mem_re)
                rd_reg <= store_mem[lane_ctl.addr];
            sum_reg <= sum_in;
            fmt_reg <= lane_ctl.fmt;
        end
    end

    always_comb begin
        total = {2'b00, rd_reg} + {2'b00, sum_reg}
              + ((fmt_reg == FMT_444) ? (SUM_W+2)'(2) : (SUM_W+2)'(1));
        case (fmt_reg)
            FMT_LUMA: result = NEUTRAL;
            FMT_420:  result = sum_reg[SAMPLE_W-1:0];
            FMT_422:  result = total[SAMPLE_W:1];
            FMT_444:  result = total[SAMPLE_W+1:2];
            default:  result = NEUTRAL;
        endcase
    end

endmodule

FILE: hdl/cds420_merge.sv
module cds420_merge
    import cds420_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  emit,
    input  logic                  last,
    input  logic [SAMPLE_W-1:0]   cb_res,
    input  logic [SAMPLE_W-1:0]   cr_res,
    output logic                  pipe_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic                  p1_valid_reg, p1_emit_reg, p1_last_reg;
    logic                  out_valid_reg;
    logic [2*SAMPLE_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_free;

    assign out_free   = !out_valid_reg || m_tready;
    // an item without a result just drops out of the first stage
    assign pipe_ready = !p1_valid_reg || !p1_emit_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p1_emit_reg   <= 1'b0;
            p1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pipe_ready) begin
                p1_valid_reg <= accept;
                p1_emit_reg  <= emit;
                p1_last_reg  <= last;
            end
            if (out_free)
                out_valid_reg <= p1_valid_reg && p1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && p1_valid_reg && p1_emit_reg) begin
            out_data_reg <= {cr_res, cb_res};
            out_last_reg <= p1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hdl/chroma_downsample_to_420_top.sv
// Channel   Dir  Ports            Contents
// s_        in   tvalid/tready    tdata[7:0] cb_sample, tdata[15:8] cr_sample
// m_        out  tvalid/tready    tdata[7:0] cb_out, tdata[15:8] cr_out, tlast frame_last
// apb       in   psel/penable     0x0 chroma_format, 0x4 frame_width, 0x8 frame_height
//
// One request per clock unless m_tready stalls; m_tvalid is registered past a first stage.
// Each lane's line store has one port and sees at most one write or read per request.
// The Cb and Cr lanes run side by side; the merge stage registers their results.
// Synchronous active-low reset clears position, pipeline valids and config registers;
// the line store is not cleared. Stalls on m_ tready hold one result and one
// request in flight, then drop s_tready.
`include "assert_macros.svh"

module chroma_downsample_to_420_top
    import cds420_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*SAMPLE_W-1:0] s_tdata,   // cb_sample, cr_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,   // cb_out, cr_out
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    lane_ctl_t           lane_ctl;
    logic                accept;
    logic                emit;
    logic                last;
    logic [SAMPLE_W-1:0] cb_res, cr_res;

    assign pready = 1'b1;
    assign accept = s_tvalid && s_tready;

    cds420_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .accept   (accept),
        .lane_ctl (lane_ctl),
        .emit     (emit),
        .last     (last)
    );

    cds420_lane u_lane_cb (
        .aclk     (aclk),
        .accept   (accept),
        .lane_ctl (lane_ctl),
        .sample   (s_tdata[SAMPLE_W-1:0]),
        .result   (cb_res)
    );

    cds420_lane u_lane_cr (
        .aclk     (aclk),
        .accept   (accept),
        .lane_ctl (lane_ctl),
        .sample   (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .result   (cr_res)
    );

    cds420_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .emit       (emit),
        .last       (last),
        .cb_res     (cb_res),
        .cr_res     (cr_res),
        .pipe_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    `ASSERT_IMPLY(a_ready_drops_only_on_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `ASSERT_IMPLY(a_store_single_access, aclk, aresetn, lane_ctl.mem_we, !lane_ctl.mem_re)
    `ASSERT_NEXT(a_stalled_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

FILE: tb/chroma_downsample_to_420_top_test.sv
`timescale 1ns / 1ps

module chroma_downsample_to_420_top_test;
    import cds420_pkg::*;

    localparam int DRAIN_CYCLES   = 8;      // pipeline is two deep; leave margin
    localparam int WATCHDOG_LIMIT = 4000;   // long hold-off is HOLD_OFF, stalls and gaps far less
    localparam int RANDOM_PAIRS   = 1300;
    localparam int HOLD_OFF       = 300;

    typedef struct {
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic                last;
    } chroma_out_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*SAMPLE_W-1:0] s_tdata  = '0;   // cb_sample, cr_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*SAMPLE_W-1:0] m_tdata;         // cb_out, cr_out
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    chroma_downsample_to_420_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // predictor state
    fmt_t                cfg_fmt    = FMT_420;
    logic [DIM_W-1:0]    cfg_width  = WIDTH_RESET;
    logic [DIM_W-1:0]    cfg_height = HEIGHT_RESET;
    int                  pos_col    = 0;
    int                  pos_row    = 0;
    logic [SAMPLE_W-1:0] held_cb    = '0;
    logic [SAMPLE_W-1:0] held_cr    = '0;
    logic [SUM_W-1:0]    line_cb [STORE_DEPTH];
    logic [SUM_W-1:0]    line_cr [STORE_DEPTH];

    logic [2*SAMPLE_W-1:0] pending_pairs[$];
    chroma_out_t           expected_420[$];
    int                    pairs_loaded   = 0;
    int                    pairs_accepted = 0;
    int                    results_seen   = 0;
    int                    mismatch_count = 0;

    function automatic int even_dim(input logic [DIM_W-1:0] v, input int hi);
        int d;
        d = int'({v[DIM_W-1:1], 1'b0});
        if (d < 2) d = 2;
        if (d > hi) d = hi & -2;
        return d;
    endfunction

    function automatic int src_cols(input fmt_t fmt, input logic [DIM_W-1:0] w);
        int ew;
        ew = even_dim(w, MAX_W_EVEN);
        return (fmt == FMT_444) ? ew : ew / 2;
    endfunction

    function automatic int src_rows(input fmt_t fmt, input logic [DIM_W-1:0] h);
        int eh;
        eh = even_dim(h, MAX_H_EVEN);
        return (fmt == FMT_422 || fmt == FMT_444) ? eh : eh / 2;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // works out the 4:2:0 output, if any, for one accepted source pair
    task automatic predict_chroma(input logic [2*SAMPLE_W-1:0] pair);
        int          cols, rows, col, row, idx, scb, scr;
        logic [7:0]  cb, cr;
        bit          emit;
        chroma_out_t r;
        cb   = pair[SAMPLE_W-1:0];
        cr   = pair[2*SAMPLE_W-1:SAMPLE_W];
        cols = src_cols(cfg_fmt, cfg_width);
        rows = src_rows(cfg_fmt, cfg_height);
        col  = pos_col;
        row  = pos_row;
        if (col >= cols) col = 0;
        if (row >= rows) row = 0;
        r.last = (col == cols - 1) && (row == rows - 1);
        r.cb   = '0;
        r.cr   = '0;
        emit   = 1'b0;
        case (cfg_fmt)
            FMT_LUMA: begin
                emit = 1'b1;
                r.cb = NEUTRAL;
                r.cr = NEUTRAL;
            end
            FMT_420: begin
                emit = 1'b1;
                r.cb = cb;
                r.cr = cr;
            end
            FMT_422: begin
                if (col < STORE_DEPTH) begin
                    if (row % 2 == 0) begin
                        line_cb[col] = SUM_W'(cb);
                        line_cr[col] = SUM_W'(cr);
                    end else begin
                        emit = 1'b1;
                        r.cb = 8'((int'(line_cb[col]) + cb + 1) >> 1);
                        r.cr = 8'((int'(line_cr[col]) + cr + 1) >> 1);
                    end
                end
            end
            default: begin
                if (col % 2 == 0) begin
                    held_cb = cb;
                    held_cr = cr;
                end else begin
                    idx = col / 2;
                    scb = int'(held_cb) + cb;
                    scr = int'(held_cr) + cr;
                    if (idx < STORE_DEPTH) begin
                        if (row % 2 == 0) begin
                            line_cb[idx] = SUM_W'(scb);
                            line_cr[idx] = SUM_W'(scr);
                        end else begin
                            emit = 1'b1;
                            r.cb = 8'((int'(line_cb[idx]) + scb + 2) >> 2);
                            r.cr = 8'((int'(line_cr[idx]) + scr + 2) >> 2);
                        end
                    end
                end
            end
        endcase
        col++;
        if (col >= cols) begin
            col = 0;
            row++;
            if (row >= rows) row = 0;
        end
        pos_col = col;
        pos_row = row;
        if (emit) expected_420.push_back(r);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FORMAT: cfg_fmt    = fmt_t'(value[1:0]);
            REG_WIDTH:  cfg_width  = value[DIM_W-1:0];
            default:    cfg_height = value[DIM_W-1:0];
        endcase
        // any write restarts the frame
        pos_col = 0;
        pos_row = 0;
        held_cb = '0;
        held_cr = '0;
    endtask

    task automatic wait_idle();
        while (pairs_accepted != pairs_loaded || expected_420.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input fmt_t fmt, input int w, input int h);
        wait_idle();
        apb_write(REG_FORMAT, APB_DATA_W'(fmt));
        apb_write(REG_WIDTH, APB_DATA_W'(w));
        apb_write(REG_HEIGHT, APB_DATA_W'(h));
    endtask

    task automatic queue_pair(input logic [2*SAMPLE_W-1:0] pair);
        pending_pairs.push_back(pair);
        pairs_loaded++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_pair((2*SAMPLE_W)'($urandom_range(0, 65535)));
    endtask

    // stimulus
    initial begin
        fmt_t fmt;
        int   w, h, per_frame, n, random_pairs;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: straight pass-through
        queue_pair(16'h0000);
        queue_pair(16'hFFFF);
        queue_pair(16'h00FF);
        queue_pair(16'hFF00);

        configure(FMT_LUMA, 4, 4);
        queue_random(4);

        // vertical average rounds half up
        configure(FMT_422, 4, 2);
        queue_pair(16'h0000);
        queue_pair(16'hFFFF);
        queue_pair(16'hFFFF);
        queue_pair(16'hFFFF);

        // odd sizes drop the low bit: 4x2, two 2x2 blocks
        configure(FMT_444, 5, 3);
        queue_pair(16'hFFFF);
        queue_pair(16'hFFFF);
        queue_pair(16'hFFFF);
        queue_pair(16'h0000);
        queue_pair(16'hFFFF);
        queue_pair(16'hFFFF);
        queue_pair(16'h0000);
        queue_pair(16'h0000);

        // size extremes and clamping
        configure(FMT_422, 8191, 8191);
        queue_random(40);
        configure(FMT_444, 4096, 4096);
        queue_random(64);
        configure(FMT_LUMA, 2, 8191);
        queue_random(50);
        configure(FMT_420, 0, 1);
        queue_random(20);
        configure(FMT_444, 1, 0);
        queue_random(12);

        random_pairs = 0;
        while (random_pairs < RANDOM_PAIRS) begin
            fmt = fmt_t'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) begin
                // wide frame, random pair count
                w = $urandom_range(21, 8191);
                h = $urandom_range(0, 8191);
                n = $urandom_range(20, 300);
            end else begin
                w = $urandom_range(0, 20);
                h = $urandom_range(0, 12);
                per_frame = src_cols(fmt, DIM_W'(w)) * src_rows(fmt, DIM_W'(h));
                n = per_frame * $urandom_range(1, 3);
                if ($urandom_range(0, 2) == 0) n += $urandom_range(0, per_frame - 1);
            end
            if (n > RANDOM_PAIRS - random_pairs) n = RANDOM_PAIRS - random_pairs;
            configure(fmt, w, h);
            queue_random(n);
            random_pairs += n;
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // source side: bursts of random length, random gaps
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_chroma(s_tdata);
                pairs_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    s_tdata  <= pending_pairs.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: checks, and a ready pattern chosen by rx_cycle[10:9]
    chroma_out_t want;
    logic [31:0] rx_cycle   = '0;
    int          stall_left = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;
    bit          rdy;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_420.size() == 0) begin
                    report_mismatch("result with none expected, cb_out", m_tdata[7:0], 0);
                end else begin
                    want = expected_420.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== want.cb)
                        report_mismatch("cb_out", m_tdata[SAMPLE_W-1:0], want.cb);
                    if (m_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.cr)
                        report_mismatch("cr_out", m_tdata[2*SAMPLE_W-1:SAMPLE_W], want.cr);
                    if (m_tlast !== want.last)
                        report_mismatch("frame_last", m_tlast, want.last);
                end
            end
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && results_seen >= 200 && m_tvalid) begin
                // one long hold-off so the block backs up onto its input
                hold_done = 1'b1;
                hold_left = HOLD_OFF;
                rdy       = 1'b0;
            end else begin
                case (rx_cycle[10:9])
                    2'd0: rdy = 1'b1;
                    2'd1: rdy = rx_cycle[1];
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            rdy = 1'b0;
                        end else if ($urandom_range(0, 3) == 0) begin
                            stall_left = $urandom_range(0, 7);
                            rdy        = 1'b0;
                        end else begin
                            rdy = 1'b1;
                        end
                    end
                endcase
            end
            m_tready <= rdy;
        end
    end

    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/cds420_pkg.sv
hdl/cds420_ctrl.sv
hdl/cds420_lane.sv
hdl/cds420_merge.sv
hdl/chroma_downsample_to_420_top.sv
tb/chroma_downsample_to_420_top_test.sv
